FILE: hdl/taf_pkg.sv
// Package for the traction assist force block: shared types and constants.
package taf_pkg;

  localparam int UNIT_SHIFT = 30;
  localparam int CFG_IDX_W  = 3;

  // Fraction bits of the Q1.x inputs; the 16-bit fields fix this at 15.
  localparam int FRAC_BITS  = 15;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FORCE      = 3'd0,
    REG_THROTTLE_GAIN  = 3'd1,
    REG_UPWARD_BIAS    = 3'd2,
    REG_MIN_CONFIDENCE = 3'd3,
    REG_CONTACT_THR    = 3'd4,
    REG_YAW_THR        = 3'd5,
    REG_THROTTLE_THR   = 3'd6
  } cfg_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic [31:0] max_force;
    logic [31:0] throttle_gain;
    logic [15:0] upward_bias;
    logic [15:0] min_confidence;
    logic [15:0] contact_threshold;
    logic [15:0] yaw_threshold;
    logic [15:0] throttle_threshold;
  } cfg_t;

endpackage

FILE: hdl/taf_cfg_regs.sv
// Configuration register file of the traction assist force block.
module taf_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output taf_pkg::cfg_t cfg
);

  // Register writes; reset loads the defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_force          <= 32'd65536000;
      cfg.throttle_gain      <= 32'd65536000;
      cfg.upward_bias        <= 16'd16384;
      cfg.min_confidence     <= 16'd9830;
      cfg.contact_threshold  <= 16'd16384;
      cfg.yaw_threshold      <= 16'd9830;
      cfg.throttle_threshold <= 16'd3277;
    end else if (cfg_we) begin
      unique case (cfg_index)
        taf_pkg::REG_MAX_FORCE:      cfg.max_force          <= cfg_data;
        taf_pkg::REG_THROTTLE_GAIN:  cfg.throttle_gain      <= cfg_data;
        taf_pkg::REG_UPWARD_BIAS:    cfg.upward_bias        <= cfg_data[15:0];
        taf_pkg::REG_MIN_CONFIDENCE: cfg.min_confidence     <= cfg_data[15:0];
        taf_pkg::REG_CONTACT_THR:    cfg.contact_threshold  <= cfg_data[15:0];
        taf_pkg::REG_YAW_THR:        cfg.yaw_threshold      <= cfg_data[15:0];
        taf_pkg::REG_THROTTLE_THR:   cfg.throttle_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/taf_sqrt_stage.sv
// One pipelined restoring square root step: two radicand bits per stage.
module taf_sqrt_stage #(
  parameter int RW = 64,
  parameter int QW = 32
) (
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] root_in,
  input  logic [1:0]    pair,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] root_out
);

  logic [RW-1:0] shifted;
  logic [RW-1:0] trial;

  // Bring down the next bit pair and try subtracting 4r+1.
  always_comb begin
    shifted = {rem_in[RW-3:0], pair};
    trial   = RW'({root_in[QW-1:0], 2'b01});
    if (shifted >= trial) begin
      rem_out  = shifted - trial;
      root_out = {root_in[QW-2:0], 1'b1};
    end else begin
      rem_out  = shifted;
      root_out = {root_in[QW-2:0], 1'b0};
    end
  end

endmodule

FILE: hdl/taf_divider.sv
// Pipelined restoring divider: a 61-bit dividend by a 31-bit divisor, one bit a stage.
module taf_divider #(
  parameter int NW = 61,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW:0]   rem  [NW+1];
  logic [NW-1:0] qacc [NW+1];
  logic [NW-1:0] nacc [NW+1];
  logic [DW-1:0] dacc [NW+1];

  assign rem[0]  = '0;
  assign qacc[0] = '0;
  assign nacc[0] = num;
  assign dacc[0] = den;

  // Each stage produces one quotient bit, most significant first.
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW+1:0] sh;
    logic [DW+1:0] diff;
    logic [DW:0]   rem_r;
    logic [NW-1:0] q_r;
    logic [NW-1:0] n_r;
    logic [DW-1:0] d_r;
    assign sh   = {rem[k], nacc[k][NW-1]};
    assign diff = sh - {2'b00, dacc[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW+1]) begin
          rem_r <= diff[DW:0];
          q_r   <= {qacc[k][NW-2:0], 1'b1};
        end else begin
          rem_r <= sh[DW:0];
          q_r   <= {qacc[k][NW-2:0], 1'b0};
        end
        n_r <= {nacc[k][NW-2:0], 1'b0};
        d_r <= dacc[k];
      end
    end
    assign rem[k+1]  = rem_r;
    assign qacc[k+1] = q_r;
    assign nacc[k+1] = n_r;
    assign dacc[k+1] = d_r;
  end

  assign quo = qacc[NW];

endmodule

FILE: hdl/traction_assist_force.sv
// Traction assist force: pipelined contact patch to force vector.
// Throughput: one request per cycle while the output is not stalled; the
// depth is mostly set by the bit-serial square root (32 stages) and the
// three unit-vector dividers (61 stages).
// Reset: synchronous; registers load their defaults, the pipeline empties.
module traction_assist_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               patch_valid,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] forward_x,
  input  logic signed [15:0] forward_y,
  input  logic signed [15:0] forward_z,
  input  logic signed [15:0] throttle,
  input  logic signed [15:0] yaw,
  input  logic [15:0]        contact_ratio,
  input  logic [15:0]        confidence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [32:0] force_x,
  output logic signed [32:0] force_y,
  output logic signed [32:0] force_z,
  output logic               assist_active
);

  localparam int FRAC_BITS = taf_pkg::FRAC_BITS;
  localparam int SQ_ST  = 32;
  localparam int DIV_NW = 61;
  localparam int DEPTH  = 12 + SQ_ST + DIV_NW;
  localparam logic signed [17:0] ONE = 18'sd1 <<< FRAC_BITS;
  localparam logic signed [47:0] HALF = 48'sd1 <<< (FRAC_BITS - 1);

  taf_pkg::cfg_t cfg;

  taf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Whole pipeline advances together; a stall freezes every stage.
  logic en;
  logic [DEPTH-1:0] vld;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end
  assign out_valid = vld[DEPTH-1];

  // Stage 1: gate, direction with sign of throttle, clamped groundness.
  logic        s1_go;
  logic signed [17:0] s1_d [3];
  logic signed [15:0] s1_n [3];
  logic signed [17:0] s1_omg;
  logic [15:0] s1_athr;
  logic [15:0] s1_def;
  logic [15:0] s1_conf;
  logic [16:0] athr0;
  logic [16:0] ayaw0;
  logic        gate0;
  logic signed [17:0] g0;

  always_comb begin
    athr0 = throttle[15] ? 17'(-$signed({throttle[15], throttle})) : {1'b0, throttle};
    ayaw0 = yaw[15] ? 17'(-$signed({yaw[15], yaw})) : {1'b0, yaw};
    gate0 = patch_valid && (contact_ratio < cfg.contact_threshold)
         && (ayaw0 < {1'b0, cfg.yaw_threshold}) && (athr0 > {1'b0, cfg.throttle_threshold})
         && (confidence >= cfg.min_confidence);
    if (normal_z <= 0)                 g0 = '0;
    else if (18'(normal_z) > ONE)      g0 = ONE;
    else                               g0 = 18'(normal_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_go   <= gate0;
      s1_n[0] <= normal_x;
      s1_n[1] <= normal_y;
      s1_n[2] <= normal_z;
      s1_d[0] <= throttle[15] ? -18'(forward_x) : 18'(forward_x);
      s1_d[1] <= throttle[15] ? -18'(forward_y) : 18'(forward_y);
      s1_d[2] <= throttle[15] ? -18'(forward_z) : 18'(forward_z);
      s1_omg  <= ONE - g0;
      s1_athr <= athr0[15:0];
      s1_def  <= (contact_ratio >= 16'(ONE)) ? 16'd0 : 16'(ONE) - contact_ratio;
      s1_conf <= confidence;
    end
  end

  // Stage 2: upward bias term; first magnitude product.
  logic signed [17:0] s2_d [3];
  logic signed [15:0] s2_n [3];
  logic        s2_go;
  logic [31:0] s2_m;
  logic [15:0] s2_conf;
  logic [34:0] ub_prod;
  assign ub_prod = cfg.upward_bias * 19'(s1_omg);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_go   <= s1_go;
      s2_n    <= s1_n;
      s2_d[0] <= s1_d[0];
      s2_d[1] <= s1_d[1];
      s2_d[2] <= s1_d[2] + 18'(ub_prod >> FRAC_BITS);
      s2_m    <= (s1_athr * s1_def) >> FRAC_BITS;
      s2_conf <= s1_conf;
    end
  end

  // Stage 3: dot product terms; second magnitude product.
  logic signed [33:0] s3_t [3];
  logic signed [17:0] s3_d [3];
  logic signed [15:0] s3_n [3];
  logic        s3_go;
  logic [31:0] s3_m;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_t[i] <= s2_d[i] * s2_n[i];
      s3_d  <= s2_d;
      s3_n  <= s2_n;
      s3_go <= s2_go;
      s3_m  <= 32'((48'(s2_m) * s2_conf) >> FRAC_BITS);
    end
  end

  // Stage 4: rounded projection coefficient; third magnitude product.
  logic signed [47:0] dot4;
  logic signed [47:0] q4;
  logic signed [31:0] s4_q;
  logic signed [17:0] s4_d [3];
  logic signed [15:0] s4_n [3];
  logic        s4_go;
  logic [63:0] s4_m;

  always_comb begin
    dot4 = 48'(s3_t[0]) + 48'(s3_t[1]) + 48'(s3_t[2]) + HALF;
    q4   = dot4 >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q  <= 32'(q4);
      s4_d  <= s3_d;
      s4_n  <= s3_n;
      s4_go <= s3_go;
      s4_m  <= s3_m * cfg.throttle_gain;
    end
  end

  // Stage 5: projected direction; magnitude shift and cap.
  logic signed [48:0] s5_p [3];
  logic        s5_go;
  logic [31:0] s5_m;
  logic [63:0] mshift5;
  assign mshift5 = s4_m >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        s5_p[i] <= 49'(s4_d[i] * ONE) - 49'(s4_q * s4_n[i]);
      s5_go <= s4_go;
      s5_m  <= (mshift5 > 64'(cfg.max_force)) ? cfg.max_force : mshift5[31:0];
    end
  end

  // Stage 6: absolute values and their maximum.
  logic [47:0] s6_mag [3];
  logic [47:0] s6_max;
  logic [2:0]  s6_neg;
  logic        s6_go;
  logic [31:0] s6_m;
  logic [47:0] a6 [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      a6[i] = s5_p[i][48] ? 48'(-s5_p[i]) : 48'(s5_p[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_mag <= a6;
      s6_max <= (a6[0] > a6[1]) ? ((a6[0] > a6[2]) ? a6[0] : a6[2])
                                : ((a6[1] > a6[2]) ? a6[1] : a6[2]);
      for (int i = 0; i < 3; i++) s6_neg[i] <= s5_p[i][48];
      s6_go <= s5_go;
      s6_m  <= s5_m;
    end
  end

  // Stage 7: leading-one position of the maximum.
  logic [5:0]  s7_lz;
  logic [47:0] s7_mag [3];
  logic [2:0]  s7_neg;
  logic        s7_go;
  logic [31:0] s7_m;
  logic [5:0]  msb7;

  always_comb begin
    msb7 = '0;
    for (int b = 0; b < 48; b++)
      if (s6_max[b]) msb7 = 6'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_lz  <= msb7;
      s7_mag <= s6_mag;
      s7_neg <= s6_neg;
      s7_go  <= s6_go && (s6_max != '0);
      s7_m   <= s6_m;
    end
  end

  // Stage 8: scale so that the maximum lies in [2^29, 2^30).
  logic [30:0] s8_mag [3];
  logic [2:0]  s8_neg;
  logic        s8_go;
  logic [31:0] s8_m;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (s7_lz >= 6'd29) s8_mag[i] <= 31'(s7_mag[i] >> (s7_lz - 6'd29));
        else                s8_mag[i] <= 31'(s7_mag[i] << (6'd29 - s7_lz));
      end
      s8_neg <= s7_neg;
      s8_go  <= s7_go;
      s8_m   <= s7_m;
    end
  end

  // Stages 9 and 10: squares, then their sum.
  logic [59:0] s9_sq [3];
  logic [30:0] s9_mag [3];
  logic [2:0]  s9_neg;
  logic        s9_go;
  logic [31:0] s9_m;
  logic [63:0] s10_sum;
  logic [30:0] s10_mag [3];
  logic [2:0]  s10_neg;
  logic        s10_go;
  logic [31:0] s10_m;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s9_sq[i] <= s8_mag[i] * s8_mag[i];
      s9_mag  <= s8_mag;
      s9_neg  <= s8_neg;
      s9_go   <= s8_go;
      s9_m    <= s8_m;
      s10_sum <= 64'(s9_sq[0]) + 64'(s9_sq[1]) + 64'(s9_sq[2]);
      s10_mag <= s9_mag;
      s10_neg <= s9_neg;
      s10_go  <= s9_go;
      s10_m   <= s9_m;
    end
  end

  // Square root pipeline, one result bit per stage.
  logic [65:0] sq_rem  [SQ_ST+1];
  logic [31:0] sq_root [SQ_ST+1];
  logic [63:0] sq_rad  [SQ_ST+1];
  logic [30:0] sq_mag  [SQ_ST+1][3];
  logic [2:0]  sq_neg  [SQ_ST+1];
  logic        sq_go   [SQ_ST+1];
  logic [31:0] sq_m    [SQ_ST+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = s10_sum;
  assign sq_mag[0]  = s10_mag;
  assign sq_neg[0]  = s10_neg;
  assign sq_go[0]   = s10_go;
  assign sq_m[0]    = s10_m;

  for (genvar k = 0; k < SQ_ST; k++) begin : g_sq
    logic [65:0] rem_n;
    logic [31:0] root_n;
    logic [65:0] rem_r;
    logic [31:0] root_r;
    logic [63:0] rad_r;
    logic [30:0] mag_r [3];
    logic [2:0]  neg_r;
    logic        go_r;
    logic [31:0] m_r;
    taf_sqrt_stage #(.RW(66), .QW(32)) u_st (
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .pair     (sq_rad[k][63:62]),
      .rem_out  (rem_n),
      .root_out (root_n)
    );
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_n;
        root_r <= root_n;
        rad_r  <= {sq_rad[k][61:0], 2'b00};
        mag_r  <= sq_mag[k];
        neg_r  <= sq_neg[k];
        go_r   <= sq_go[k];
        m_r    <= sq_m[k];
      end
    end
    assign sq_rem[k+1]  = rem_r;
    assign sq_root[k+1] = root_r;
    assign sq_rad[k+1]  = rad_r;
    assign sq_mag[k+1]  = mag_r;
    assign sq_neg[k+1]  = neg_r;
    assign sq_go[k+1]   = go_r;
    assign sq_m[k+1]    = m_r;
  end

  // Unit components: magnitude * 2^30 / length, three dividers in parallel.
  logic [DIV_NW-1:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_dv
    taf_divider #(.NW(DIV_NW), .DW(31)) u_div (
      .clk (clk),
      .en  (en),
      .num ({sq_mag[SQ_ST][i], 30'd0}),
      .den (sq_root[SQ_ST][30:0]),
      .quo (quo[i])
    );
  end

  // Side data travels beside the dividers.
  logic [2:0]  dl_neg [DIV_NW+1];
  logic        dl_go  [DIV_NW+1];
  logic [31:0] dl_m   [DIV_NW+1];
  assign dl_neg[0] = sq_neg[SQ_ST];
  assign dl_go[0]  = sq_go[SQ_ST];
  assign dl_m[0]   = sq_m[SQ_ST];
  for (genvar k = 0; k < DIV_NW; k++) begin : g_dl
    logic [2:0]  neg_r;
    logic        go_r;
    logic [31:0] m_r;
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r <= dl_neg[k];
        go_r  <= dl_go[k];
        m_r   <= dl_m[k];
      end
    end
    assign dl_neg[k+1] = neg_r;
    assign dl_go[k+1]  = go_r;
    assign dl_m[k+1]   = m_r;
  end

  // Cap the unit components at one, then scale by the magnitude.
  logic [30:0] fu [3];
  logic [62:0] fp [3];
  logic [2:0]  fneg;
  logic        fgo;
  always_comb begin
    for (int i = 0; i < 3; i++)
      fu[i] = (quo[i] > DIV_NW'(64'd1 << taf_pkg::UNIT_SHIFT))
            ? 31'(64'd1 << taf_pkg::UNIT_SHIFT) : quo[i][30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) fp[i] <= fu[i] * dl_m[DIV_NW];
      fneg <= dl_neg[DIV_NW];
      fgo  <= dl_go[DIV_NW];
    end
  end

  // Output register: shift, apply sign, zero when the gate is closed.
  logic [32:0] fm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) fm[i] = 33'(fp[i] >> taf_pkg::UNIT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x       <= !fgo ? '0 : (fneg[0] ? -fm[0] : fm[0]);
      force_y       <= !fgo ? '0 : (fneg[1] ? -fm[1] : fm[1]);
      force_z       <= !fgo ? '0 : (fneg[2] ? -fm[2] : fm[2]);
      assist_active <= fgo;
    end
  end

endmodule

FILE: sim/tb_traction_assist_force.sv
// Self-checking testbench for the traction assist force block.
module tb_traction_assist_force;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = taf_pkg::FRAC_BITS;
  localparam int LATENCY = 105;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic               pv;
    logic signed [15:0] nx, ny, nz, fx, fy, fz, thr, yw;
    logic [15:0]        cr, cf;
  } patch_t;

  typedef struct {
    logic signed [32:0] fx, fy, fz;
    logic               active;
  } force_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic patch_valid = 0;
  logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
  logic signed [15:0] forward_x = 0, forward_y = 0, forward_z = 0;
  logic signed [15:0] throttle = 0, yaw = 0;
  logic [15:0] contact_ratio = 0, confidence = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [32:0] force_x, force_y, force_z;
  logic assist_active;

  traction_assist_force u_top (.*);

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers.
  taf_pkg::cfg_t cfg;
  force_t expected_forces[$];
  int errors = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input logic [32:0] got, input logic [32:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Predicts the force vector for one patch under the current registers.
  function automatic force_t predict_force(input patch_t pt);
    force_t res;
    longint one, n[3], d[3], p[3], sgn, g, ub, dot, q, athr, ayaw;
    logic [63:0] mag[3], maxm, sum, len, m, def, u, f;
    one = 64'sd1 << FRAC;
    res = '{0, 0, 0, 0};
    athr = pt.thr < 0 ? -longint'(pt.thr) : longint'(pt.thr);
    ayaw = pt.yw < 0 ? -longint'(pt.yw) : longint'(pt.yw);
    if (!pt.pv || pt.cr >= cfg.contact_threshold || ayaw >= cfg.yaw_threshold ||
        athr <= cfg.throttle_threshold || pt.cf < cfg.min_confidence)
      return res;
    sgn = pt.thr < 0 ? -1 : 1;
    n[0] = pt.nx; n[1] = pt.ny; n[2] = pt.nz;
    d[0] = sgn * pt.fx; d[1] = sgn * pt.fy; d[2] = sgn * pt.fz;
    g = n[2] > 0 ? (n[2] > one ? one : n[2]) : 0;
    ub = longint'((64'(cfg.upward_bias) * 64'(one - g)) >> FRAC);
    d[2] += ub;
    dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    q = (dot + (one >>> 1)) >>> FRAC;
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = d[i] * one - q * n[i];
      mag[i] = p[i] < 0 ? -p[i] : p[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm == 0) return res;
    while (maxm >= (64'd1 << taf_pkg::UNIT_SHIFT)) begin
      maxm >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (maxm < (64'd1 << (taf_pkg::UNIT_SHIFT - 1))) begin
      maxm <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = isqrt(sum);
    def = pt.cr >= one ? 0 : one - pt.cr;
    m = (64'(athr) * def) >> FRAC;
    m = (m * pt.cf) >> FRAC;
    m = (m * cfg.throttle_gain) >> FRAC;
    if (m > cfg.max_force) m = cfg.max_force;
    for (int i = 0; i < 3; i++) begin
      u = (mag[i] << taf_pkg::UNIT_SHIFT) / len;
      if (u > (64'd1 << taf_pkg::UNIT_SHIFT)) u = 64'd1 << taf_pkg::UNIT_SHIFT;
      f = (u * m) >> taf_pkg::UNIT_SHIFT;
      if (p[i] < 0) f = -f;
      if (i == 0) res.fx = f[32:0];
      else if (i == 1) res.fy = f[32:0];
      else res.fz = f[32:0];
    end
    res.active = 1;
    return res;
  endfunction

  // Sends one request after a random gap and queues its expected force.
  // Valid stays high after acceptance; the next call or the caller drops it.
  task automatic send_patch(input patch_t pt);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    patch_valid <= pt.pv;
    normal_x <= pt.nx; normal_y <= pt.ny; normal_z <= pt.nz;
    forward_x <= pt.fx; forward_y <= pt.fy; forward_z <= pt.fz;
    throttle <= pt.thr; yaw <= pt.yw;
    contact_ratio <= pt.cr; confidence <= pt.cf;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    expected_forces.push_back(predict_force(pt));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    wait (expected_forces.size() == 0);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input taf_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      taf_pkg::REG_MAX_FORCE:      cfg.max_force = val;
      taf_pkg::REG_THROTTLE_GAIN:  cfg.throttle_gain = val;
      taf_pkg::REG_UPWARD_BIAS:    cfg.upward_bias = val[15:0];
      taf_pkg::REG_MIN_CONFIDENCE: cfg.min_confidence = val[15:0];
      taf_pkg::REG_CONTACT_THR:    cfg.contact_threshold = val[15:0];
      taf_pkg::REG_YAW_THR:        cfg.yaw_threshold = val[15:0];
      taf_pkg::REG_THROTTLE_THR:   cfg.throttle_threshold = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] q15_rand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly gate-passing patches with random geometry; some pure noise.
  function automatic patch_t random_patch();
    patch_t pt;
    pt.nx = q15_rand(); pt.ny = q15_rand(); pt.nz = q15_rand();
    pt.fx = q15_rand(); pt.fy = q15_rand(); pt.fz = q15_rand();
    if ($urandom_range(0, 4) == 0) begin
      pt.pv = 1'($urandom()); pt.thr = 16'($urandom()); pt.yw = 16'($urandom());
      pt.cr = 16'($urandom()); pt.cf = 16'($urandom());
    end else begin
      pt.pv = 1;
      pt.thr = 16'($urandom_range(cfg.throttle_threshold + 1, 32767));
      if ($urandom_range(0, 1)) pt.thr = -pt.thr;
      pt.yw = cfg.yaw_threshold == 0 ? 16'sd0 :
              16'($urandom_range(0, cfg.yaw_threshold - 1));
      if (pt.yw != 0 && $urandom_range(0, 1)) pt.yw = -pt.yw;
      pt.cr = cfg.contact_threshold == 0 ? 16'd0 :
              16'($urandom_range(0, cfg.contact_threshold - 1));
      pt.cf = 16'($urandom_range(cfg.min_confidence, 65535));
    end
    return pt;
  endfunction

  function automatic patch_t gated_patch(input logic [15:0] thr);
    patch_t pt;
    pt = '{1, 0, 0, 16'sh7fff, 16'sh7fff, 0, 0, thr, 0, 0, 16'h8000};
    return pt;
  endfunction

  // Directed extremes, gate edges and the zero-direction case.
  task automatic test_directed();
    patch_t pt;
    send_patch(gated_patch(16'sh7fff));
    send_patch(gated_patch(16'sh8000));
    pt = gated_patch(16'sh4000); pt.pv = 0; send_patch(pt);
    pt = gated_patch(16'sh4000); pt.cr = cfg.contact_threshold; send_patch(pt);
    pt = gated_patch(16'sh4000); pt.yw = cfg.yaw_threshold; send_patch(pt);
    pt = gated_patch(16'sh4000); pt.yw = -cfg.yaw_threshold; send_patch(pt);
    send_patch(gated_patch(cfg.throttle_threshold));
    send_patch(gated_patch(16'(cfg.throttle_threshold + 1)));
    pt = gated_patch(16'sh4000); pt.cf = 16'(cfg.min_confidence - 1); send_patch(pt);
    pt = gated_patch(16'sh4000); pt.cf = 16'hffff; send_patch(pt);
    // Zero forward and no bias lift on a near-flat normal: the direction is empty.
    pt = gated_patch(16'sh4000); pt.nz = 16'sh7fff; pt.fx = 0; pt.fz = 0;
    send_patch(pt);
    pt = gated_patch(16'sh4000); pt.nz = 16'sh7fff; pt.fx = 0; pt.fz = 16'sh8000;
    send_patch(pt);
    pt = gated_patch(16'sh4000); pt.nz = 16'sh8000; send_patch(pt);
    pt = gated_patch(16'sh4000); pt.nz = 16'sh8000; pt.nx = 16'sh8000;
    pt.ny = 16'sh8000; pt.fy = 16'sh8000; pt.fz = 16'sh8000; send_patch(pt);
    pt = gated_patch(16'sh4000); pt.cr = 16'hffff; send_patch(pt);
    pt = gated_patch(16'sh4000); pt.cr = 16'h8000; send_patch(pt);
    pt = gated_patch(16'sh8000); pt.nx = 16'sh7fff; pt.nz = 0; pt.ny = 16'sh7fff;
    pt.fy = 16'sh7fff; pt.fz = 16'sh7fff; send_patch(pt);
    drain();
  endtask

  task automatic random_batch(input int count);
    for (int i = 0; i < count; i++) begin
      send_patch(random_patch());
      // Hold back once so the pipeline runs completely empty.
      if (i == count / 2) begin
        in_valid <= 0;
        wait (expected_forces.size() == 0);
        @(negedge clk);
      end
    end
    drain();
  endtask

  // Random traffic under several register settings, extremes included.
  task automatic test_register_settings();
    random_batch(250);
    write_reg(taf_pkg::REG_MAX_FORCE, 32'hffffffff);
    write_reg(taf_pkg::REG_THROTTLE_GAIN, 32'hffffffff);
    write_reg(taf_pkg::REG_UPWARD_BIAS, 32'h8000);
    write_reg(taf_pkg::REG_MIN_CONFIDENCE, 32'd0);
    write_reg(taf_pkg::REG_CONTACT_THR, 32'h8000);
    write_reg(taf_pkg::REG_YAW_THR, 32'h8000);
    write_reg(taf_pkg::REG_THROTTLE_THR, 32'd0);
    random_batch(250);
    write_reg(taf_pkg::REG_MAX_FORCE, 32'd0);
    write_reg(taf_pkg::REG_UPWARD_BIAS, 32'd0);
    write_reg(taf_pkg::REG_MIN_CONFIDENCE, 32'h8000);
    write_reg(taf_pkg::REG_THROTTLE_THR, 32'h7ffe);
    random_batch(80);
    write_reg(taf_pkg::REG_MAX_FORCE, $urandom());
    write_reg(taf_pkg::REG_THROTTLE_GAIN, $urandom());
    write_reg(taf_pkg::REG_UPWARD_BIAS, $urandom_range(0, 32768));
    write_reg(taf_pkg::REG_MIN_CONFIDENCE, $urandom_range(0, 32768));
    write_reg(taf_pkg::REG_CONTACT_THR, $urandom_range(1, 32768));
    write_reg(taf_pkg::REG_YAW_THR, $urandom_range(1, 32768));
    write_reg(taf_pkg::REG_THROTTLE_THR, $urandom_range(0, 30000));
    random_batch(500);
  endtask

  // Receiver: random back-pressure and the result check.
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if ($urandom_range(0, 2) == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 9) < 5);
  end

  always @(posedge clk) begin
    force_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_forces.pop_front();
        if (force_x !== want.fx) report("force_x", force_x, want.fx);
        if (force_y !== want.fy) report("force_y", force_y, want.fy);
        if (force_z !== want.fz) report("force_z", force_z, want.fz);
        if (assist_active !== want.active)
          report("assist_active", assist_active, want.active);
      end
    end
  end

  // Watchdog on cycles without any accepted request or accepted result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cfg.max_force = 65536000;
    cfg.throttle_gain = 65536000;
    cfg.upward_bias = 16384;
    cfg.min_confidence = 9830;
    cfg.contact_threshold = 16384;
    cfg.yaw_threshold = 9830;
    cfg.throttle_threshold = 3277;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_register_settings();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
